>>> hdl/mandelbrot_escape_pixel_top_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef MANDELBROT_ESCAPE_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_TOP_DEFINES_SVH
`ifndef SYNTH
`define MEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/mep_pkg.sv
`default_nettype none
package mep_pkg;

    localparam int FRAC_BITS_DEF = 28;

    localparam int ROW_W   = 14;
    localparam int DIM_W   = 15;
    localparam int ITER_W  = 16;
    localparam int SHADE_W = 8;
    localparam int DEN_W   = 16;
    localparam int NUM_W   = 17;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(1024);
    localparam logic [ITER_W-1:0] MAXIT_RST  = ITER_W'(10000);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(11);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MAXIT  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        PR_XX = 2'd0,
        PR_YY = 2'd1,
        PR_XY = 2'd2
    } t_prod;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROWMOD,
        S_COLMOD,
        S_YRATIO,
        S_XRATIO,
        S_LOOP,
        S_MUL,
        S_ACC,
        S_TEST,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hdl/mep_pix_if.sv
`default_nettype none
interface mep_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mep_pkg::ROW_W-1:0] row;
    logic [mep_pkg::ROW_W-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink (input valid, input row, input col, output ready);
endinterface
`default_nettype wire

>>> hdl/mep_shade_if.sv
`default_nettype none
interface mep_shade_if;
    logic                        valid;
    logic                        ready;
    logic [mep_pkg::SHADE_W-1:0] shade;

    modport source (output valid, output shade, input ready);
    modport sink (input valid, input shade, output ready);
endinterface
`default_nettype wire

>>> hdl/mep_div.sv
`default_nettype none
module mep_div #(
    parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_start,
    input  wire logic [FRAC_BITS+mep_pkg::NUM_W-1:0]      i_dividend,
    input  wire logic [mep_pkg::DEN_W-1:0]                i_divisor,
    output logic                                          o_done,
    output logic [FRAC_BITS+mep_pkg::NUM_W-1:0]           o_quot,
    output logic [mep_pkg::DEN_W-1:0]                     o_rem
);

    localparam int DW = FRAC_BITS + mep_pkg::NUM_W;
    localparam int CW = $clog2(DW + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [DW-1:0]             r_dvd;
    logic [DW-1:0]             r_quo;
    logic [mep_pkg::DEN_W-1:0] r_rem;
    logic [mep_pkg::DEN_W-1:0] r_den;

    logic [mep_pkg::DEN_W:0]   w_trial;
    logic                      w_ge;
    logic [mep_pkg::DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[mep_pkg::DEN_W-1:0] : w_trial[mep_pkg::DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

>>> hdl/mandelbrot_escape_pixel_top.sv
// Channel   Dir  Payload                 Role
// i_pix     in   row[13:0], col[13:0]    pixel to shade
// o_shade   out  shade[7:0]              escape count times five, zero when above 255
// apb       in   3 registers at 0x0-0x8  width, height, iteration limit
//
// Mapping takes four serial divisions.
// Each iteration then forms its partial products on the one shared multiplier.
// A word ends when its iteration count reaches the limit or when the point escapes.
// Synchronous active-low reset restores the register defaults and idles the block.
// One word is in work at a time; input ready is low until the shade word is taken.
`default_nettype none
`include "mandelbrot_escape_pixel_top_defines.svh"
module mandelbrot_escape_pixel_top #(
    parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mep_pix_if.sink                            i_pix,
    mep_shade_if.source                        o_shade,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mep_pkg::APB_AW-1:0]    paddr,
    input  wire logic [mep_pkg::APB_DW-1:0]    pwdata,
    output logic [mep_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int W    = FRAC_BITS + 4;
    localparam int MAGW = FRAC_BITS + 3;
    localparam int H    = (MAGW + 1) / 2;
    localparam int MW   = 2 * H;
    localparam int AW   = 4 * H + 2;
    localparam int DW   = FRAC_BITS + mep_pkg::NUM_W;

    localparam logic [W-1:0]  X_OFF = W'(5) << (FRAC_BITS - 1);
    localparam logic [W-1:0]  Y_OFF = W'(7) << (FRAC_BITS - 2);
    localparam logic [AW-1:0] LIMIT = AW'(1) << (2 * FRAC_BITS + 2);

    mep_pkg::t_state r_state, n_state;

    logic [mep_pkg::DIM_W-1:0]  r_img_w, r_img_h;
    logic [mep_pkg::ITER_W-1:0] r_max_iter;

    logic [mep_pkg::ROW_W-1:0]  r_col_in, r_row_m, r_col_m;
    logic [mep_pkg::ROW_W-1:0]  n_col_in, n_row_m, n_col_m;
    logic [W-1:0]               r_x0, r_y0, r_x, r_y;
    logic [W-1:0]               n_x0, n_y0, n_x, n_y;
    logic [MW-1:0]              r_mx, r_my, n_mx, n_my;
    logic                       r_sd, n_sd;
    logic [mep_pkg::ITER_W-1:0] r_iter, n_iter;
    logic [mep_pkg::STEP_W-1:0] r_step, n_step;

    logic [MW-1:0]              r_pp;
    mep_pkg::t_prod             r_pp_sel;
    logic [1:0]                 r_pp_sh;
    logic                       r_pp_vld;
    logic [AW-1:0]              r_sum, r_dif, r_xy;

    logic                       w_div_start, w_div_done;
    logic [DW-1:0]              w_div_dvd, w_div_quot;
    logic [mep_pkg::DEN_W-1:0]  w_div_den, w_div_rem;

    logic [mep_pkg::DIM_W-1:0]  w_w_eff, w_h_eff;
    logic [mep_pkg::NUM_W-1:0]  w_row7, w_col7;
    logic                       w_accept, w_escape;
    logic [W-1:0]               w_ax, w_ay;
    mep_pkg::t_prod             w_sel;
    logic [MW-1:0]              w_opa, w_opb;
    logic [H-1:0]               w_ha, w_hb;
    logic [MW-1:0]              w_prod;
    logic [AW-1:0]              w_pp_ext;
    logic [18:0]                w_shade5;

    assign w_w_eff  = (r_img_w == '0) ? mep_pkg::DIM_W'(1) : r_img_w;
    assign w_h_eff  = (r_img_h == '0) ? mep_pkg::DIM_W'(1) : r_img_h;
    assign w_row7   = ({3'b0, r_row_m} << 3) - {3'b0, r_row_m};
    assign w_col7   = ({3'b0, r_col_m} << 3) - {3'b0, r_col_m};
    assign w_accept = i_pix.valid && i_pix.ready;
    assign w_escape = (r_sum > LIMIT);

    assign i_pix.ready   = (r_state == mep_pkg::S_IDLE);
    assign o_shade.valid = (r_state == mep_pkg::S_OUT);
    assign w_shade5      = ({3'b0, r_iter} << 2) + {3'b0, r_iter};
    assign o_shade.shade = (w_shade5[18:8] == '0) ? w_shade5[7:0] : '0;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= mep_pkg::WIDTH_RST;
            r_img_h    <= mep_pkg::HEIGHT_RST;
            r_max_iter <= mep_pkg::MAXIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (mep_pkg::t_reg_idx'(paddr[3:2]))
                mep_pkg::REG_WIDTH:  r_img_w    <= pwdata[mep_pkg::DIM_W-1:0];
                mep_pkg::REG_HEIGHT: r_img_h    <= pwdata[mep_pkg::DIM_W-1:0];
                mep_pkg::REG_MAXIT:  r_max_iter <= pwdata[mep_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (mep_pkg::t_reg_idx'(paddr[3:2]))
            mep_pkg::REG_WIDTH:  prdata = mep_pkg::APB_DW'(r_img_w);
            mep_pkg::REG_HEIGHT: prdata = mep_pkg::APB_DW'(r_img_h);
            mep_pkg::REG_MAXIT:  prdata = mep_pkg::APB_DW'(r_max_iter);
            default:             prdata = '0;
        endcase
    end

    mep_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Shared multiplier operand selection.
    assign w_sel  = mep_pkg::t_prod'(r_step[3:2]);
    assign w_opa  = (w_sel == mep_pkg::PR_YY) ? r_my : r_mx;
    assign w_opb  = (w_sel == mep_pkg::PR_XX) ? r_mx : r_my;
    assign w_ha   = r_step[1] ? w_opa[MW-1:H] : w_opa[H-1:0];
    assign w_hb   = r_step[0] ? w_opb[MW-1:H] : w_opb[H-1:0];
    assign w_prod = w_ha * w_hb;
    assign w_ax   = r_x[W-1] ? (~r_x + W'(1)) : r_x;
    assign w_ay   = r_y[W-1] ? (~r_y + W'(1)) : r_y;

    always_comb begin
        unique case (r_pp_sh)
            2'd0:    w_pp_ext = AW'(r_pp);
            2'd1:    w_pp_ext = AW'(r_pp) << H;
            2'd2:    w_pp_ext = AW'(r_pp) << (2 * H);
            default: w_pp_ext = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mep_pkg::S_IDLE:   if (w_accept)   n_state = mep_pkg::S_ROWMOD;
            mep_pkg::S_ROWMOD: if (w_div_done) n_state = mep_pkg::S_COLMOD;
            mep_pkg::S_COLMOD: if (w_div_done) n_state = mep_pkg::S_YRATIO;
            mep_pkg::S_YRATIO: if (w_div_done) n_state = mep_pkg::S_XRATIO;
            mep_pkg::S_XRATIO: if (w_div_done) n_state = mep_pkg::S_LOOP;
            mep_pkg::S_LOOP: begin
                n_state = (r_iter < r_max_iter) ? mep_pkg::S_MUL : mep_pkg::S_OUT;
            end
            mep_pkg::S_MUL:    if (r_step == mep_pkg::STEP_LAST) n_state = mep_pkg::S_ACC;
            mep_pkg::S_ACC:    n_state = mep_pkg::S_TEST;
            mep_pkg::S_TEST:   n_state = w_escape ? mep_pkg::S_OUT : mep_pkg::S_LOOP;
            mep_pkg::S_OUT:    if (o_shade.ready) n_state = mep_pkg::S_IDLE;
            default:           n_state = mep_pkg::S_IDLE;
        endcase
    end

    // Datapath control and next values.
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_den   = mep_pkg::DEN_W'(w_w_eff);
        n_col_in    = r_col_in;
        n_row_m     = r_row_m;
        n_col_m     = r_col_m;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x         = r_x;
        n_y         = r_y;
        n_mx        = r_mx;
        n_my        = r_my;
        n_sd        = r_sd;
        n_iter      = r_iter;
        n_step      = r_step;
        unique case (r_state)
            mep_pkg::S_IDLE: begin
                w_div_start = w_accept;
                w_div_dvd   = DW'(i_pix.row);
                w_div_den   = mep_pkg::DEN_W'(w_h_eff);
                if (w_accept) begin
                    n_col_in = i_pix.col;
                end
            end
            mep_pkg::S_ROWMOD: begin
                w_div_start = w_div_done;
                w_div_dvd   = DW'(r_col_in);
                w_div_den   = mep_pkg::DEN_W'(w_w_eff);
                if (w_div_done) begin
                    n_row_m = w_div_rem[mep_pkg::ROW_W-1:0];
                end
            end
            mep_pkg::S_COLMOD: begin
                w_div_start = w_div_done;
                w_div_dvd   = {w_row7, {FRAC_BITS{1'b0}}};
                w_div_den   = {w_h_eff, 1'b0};
                if (w_div_done) begin
                    n_col_m = w_div_rem[mep_pkg::ROW_W-1:0];
                end
            end
            mep_pkg::S_YRATIO: begin
                w_div_start = w_div_done;
                w_div_dvd   = {w_col7, {FRAC_BITS{1'b0}}};
                w_div_den   = {w_w_eff, 1'b0};
                if (w_div_done) begin
                    n_y0 = W'(w_div_quot[FRAC_BITS+1:0]) - Y_OFF;
                end
            end
            mep_pkg::S_XRATIO: begin
                if (w_div_done) begin
                    n_x0   = W'(w_div_quot[FRAC_BITS+1:0]) - X_OFF;
                    n_x    = '0;
                    n_y    = '0;
                    n_iter = '0;
                end
            end
            mep_pkg::S_LOOP: begin
                n_mx   = MW'(w_ax[MAGW-1:0]);
                n_my   = MW'(w_ay[MAGW-1:0]);
                n_sd   = r_x[W-1] ^ r_y[W-1];
                n_step = '0;
            end
            mep_pkg::S_MUL: begin
                n_step = r_step + mep_pkg::STEP_W'(1);
            end
            mep_pkg::S_ACC: ;
            mep_pkg::S_TEST: begin
                if (!w_escape) begin
                    n_x    = r_dif[FRAC_BITS +: W] + r_x0;
                    n_y    = r_xy[FRAC_BITS-1 +: W] + r_y0;
                    n_iter = r_iter + mep_pkg::ITER_W'(1);
                end
            end
            mep_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mep_pkg::S_IDLE;
            r_pp_vld <= 1'b0;
            r_iter   <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_pp_vld <= (r_state == mep_pkg::S_MUL);
            r_iter   <= n_iter;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_in <= n_col_in;
        r_row_m  <= n_row_m;
        r_col_m  <= n_col_m;
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_x      <= n_x;
        r_y      <= n_y;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_sd     <= n_sd;
        r_pp     <= w_prod;
        r_pp_sel <= w_sel;
        r_pp_sh  <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
    end

    // Partial products are registered and land in the cycle after they are formed.
    always_ff @(posedge i_clk) begin
        if (r_state == mep_pkg::S_LOOP) begin
            r_sum <= '0;
            r_dif <= '0;
            r_xy  <= '0;
        end else if (r_pp_vld) begin
            unique case (r_pp_sel)
                mep_pkg::PR_XX: begin
                    r_sum <= r_sum + w_pp_ext;
                    r_dif <= r_dif + w_pp_ext;
                end
                mep_pkg::PR_YY: begin
                    r_sum <= r_sum + w_pp_ext;
                    r_dif <= r_dif - w_pp_ext;
                end
                mep_pkg::PR_XY: begin
                    r_xy <= r_sd ? (r_xy - w_pp_ext) : (r_xy + w_pp_ext);
                end
                default: ;
            endcase
        end
    end

    `MEP_ASSERT_IMP(a_one_word, i_clk, i_rst_n, o_shade.valid, !i_pix.ready)
    `MEP_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, w_div_done,
        (r_state == mep_pkg::S_ROWMOD) || (r_state == mep_pkg::S_COLMOD) ||
        (r_state == mep_pkg::S_YRATIO) || (r_state == mep_pkg::S_XRATIO))
    `MEP_ASSERT_IMP(a_pp_in_mul, i_clk, i_rst_n, r_pp_vld,
        (r_state == mep_pkg::S_MUL) || (r_state == mep_pkg::S_ACC))
    `MEP_ASSERT_NXT(a_iter_step, i_clk, i_rst_n, (r_state == mep_pkg::S_TEST) && !w_escape,
        r_iter == $past(r_iter) + mep_pkg::ITER_W'(1))

endmodule
`default_nettype wire
